FILE: src/idle_sleep_coordinator_unit_defines.svh
// Assertion macros shared by the idle sleep coordinator RTL.
`ifndef IDLE_SLEEP_COORDINATOR_UNIT_DEFINES_SVH
`define IDLE_SLEEP_COORDINATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("isc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ISC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("isc: next-cycle check failed");

`endif

FILE: src/isc_pkg.sv
// Package with the types, codes and update functions of the idle sleep coordinator.
package isc_pkg;

    typedef enum logic [1:0] {
        MODE_ACTIVE = 2'd0,
        MODE_IDLE   = 2'd1,
        MODE_SLEEP  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        FUNC_POLL       = 3'd0,
        FUNC_LIGHT      = 3'd1,
        FUNC_INDICATOR  = 3'd2,
        FUNC_USB        = 3'd3,
        FUNC_USER_WAKE  = 3'd4,
        FUNC_REMOTE     = 3'd5,
        FUNC_COMMISSION = 3'd6
    } func_t;

    typedef enum logic [2:0] {
        CFG_GATE_ON_IDLE   = 3'd0,
        CFG_IDLE_SETTLE    = 3'd1,
        CFG_USER_HOLD      = 3'd2,
        CFG_MATTER_HOLD    = 3'd3,
        CFG_USB_PERIOD     = 3'd4
    } cfg_index_t;

    localparam int HB_LIGHT      = 0;
    localparam int HB_INDICATOR  = 1;
    localparam int HB_USB        = 2;
    localparam int HB_BUTTON     = 3;
    localparam int HB_USER       = 4;
    localparam int HB_COMMISSION = 5;
    localparam int HB_DEBUG      = 6;

    localparam logic        GATE_RESET         = 1'b1;
    localparam logic [15:0] IDLE_SETTLE_RESET  = 16'd3000;
    localparam logic [15:0] USER_HOLD_RESET    = 16'd2000;
    localparam logic [15:0] MATTER_HOLD_RESET  = 16'd8000;
    localparam logic [15:0] USB_PERIOD_RESET   = 16'd1000;

    typedef struct packed {
        mode_t       mode;
        logic [6:0]  holds;
        logic [15:0] idle_time;
        logic [15:0] wake_left;
        logic [15:0] usb_time;
        logic        suspended;
        logic        pulse_suspend;
        logic        pulse_resume;
    } ctx_t;

    function automatic logic [15:0] sat_add16(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic ctx_t go_active(ctx_t c);
        ctx_t r;
        r = c;
        if (r.suspended)
        begin
            r.suspended    = 1'b0;
            r.pulse_resume = 1'b1;
        end
        r.idle_time = '0;
        r.mode      = MODE_ACTIVE;
        return r;
    endfunction

    function automatic ctx_t evaluate(ctx_t c, logic gate, logic [15:0] settle);
        ctx_t r;
        r = c;
        if (!gate || (r.holds != '0))
        begin
            r = go_active(r);
        end
        else if (r.mode == MODE_SLEEP)
        begin
            r = c;
        end
        else if (r.mode != MODE_IDLE)
        begin
            r.idle_time = '0;
            r.mode      = MODE_IDLE;
        end
        else if (r.idle_time >= settle)
        begin
            r.suspended     = 1'b1;
            r.pulse_suspend = 1'b1;
            r.mode          = MODE_SLEEP;
        end
        return r;
    endfunction

    function automatic ctx_t usb_event(ctx_t c, logic present, logic allow,
                                       logic gate, logic [15:0] settle);
        ctx_t r;
        r = c;
        r.holds[HB_USB] = present;
        if (!allow)
        begin
            if (present)
            begin
                r.idle_time = '0;
                r.mode      = MODE_ACTIVE;
            end
            else if ((r.holds == '0) && (r.mode == MODE_ACTIVE))
            begin
                r.idle_time = '0;
                r.mode      = MODE_IDLE;
            end
        end
        else
        begin
            if (present)
            begin
                r = go_active(r);
            end
            r = evaluate(r, gate, settle);
        end
        return r;
    endfunction

    function automatic ctx_t level_event(ctx_t c, int bit_idx, logic lvl,
                                         logic gate, logic [15:0] settle);
        ctx_t r;
        r = c;
        r.holds[bit_idx] = lvl;
        if (lvl)
        begin
            r = go_active(r);
        end
        return evaluate(r, gate, settle);
    endfunction

endpackage

FILE: src/idle_sleep_coordinator_unit.sv
// Top level of the idle sleep coordinator: input register, update logic and result register.
//
// Usage: event and poll items enter on the input channel (in_valid/in_ready with
// func, level, allow_io and elapsed_ms); each item yields exactly one result beat on
// the output channel (out_valid/out_ready with run_state, hold_mask,
// peripherals_suspended, suspend_pulse and resume_pulse). Registers are written
// through the cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data), which is
// always ready and should only be used while no item is in flight.
// Each item passes through the input register, then the state update and result are
// registered together. One item is accepted every cycle while the receiver does not
// stall; the rate is set by the single update stage that reads and writes the
// coordinator state.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one further item if it is empty, after which in_ready drops.
// Reset clears both stages, loads the register defaults (gating on, settle 3000 ms,
// user hold 2000 ms, remote hold 8000 ms, USB period 1000 ms) and puts the block
// in the active state with no holds.
`include "idle_sleep_coordinator_unit_defines.svh"

module idle_sleep_coordinator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic        level,
    input  logic        allow_io,
    input  logic [15:0] elapsed_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  run_state,
    output logic [6:0]  hold_mask,
    output logic        peripherals_suspended,
    output logic        suspend_pulse,
    output logic        resume_pulse,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import isc_pkg::*;

    logic        in_valid_reg;
    logic [2:0]  func_reg;
    logic        level_reg;
    logic        allow_io_reg;
    logic [15:0] elapsed_reg;

    logic        out_valid_reg;
    logic [1:0]  run_state_reg;
    logic [6:0]  hold_mask_reg;
    logic        suspended_out_reg;
    logic        suspend_pulse_reg;
    logic        resume_pulse_reg;

    logic        gate_reg;
    logic [15:0] settle_reg;
    logic [15:0] user_hold_reg;
    logic [15:0] matter_hold_reg;
    logic [15:0] usb_period_reg;

    mode_t       mode_reg;
    logic [6:0]  holds_reg;
    logic [15:0] idle_time_reg;
    logic [15:0] wake_left_reg;
    logic [15:0] usb_time_reg;
    logic        suspended_reg;

    logic        advance;
    logic        work;
    logic        cfg_write;
    ctx_t        cur;
    ctx_t        ctx_next;

    assign advance   = !out_valid_reg || out_ready;
    assign work      = in_valid_reg && advance;
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign cur = '{mode: mode_reg, holds: holds_reg, idle_time: idle_time_reg,
                   wake_left: wake_left_reg, usb_time: usb_time_reg,
                   suspended: suspended_reg, pulse_suspend: 1'b0, pulse_resume: 1'b0};

    always_comb
    begin
        ctx_next = cur;
        case (func_t'(func_reg))
            FUNC_POLL:
            begin
                if (ctx_next.wake_left != '0)
                begin
                    if (elapsed_reg >= ctx_next.wake_left)
                    begin
                        ctx_next.wake_left         = '0;
                        ctx_next.holds[HB_BUTTON]  = 1'b0;
                        ctx_next.holds[HB_USER]    = 1'b0;
                        ctx_next = evaluate(ctx_next, gate_reg, settle_reg);
                    end
                    else
                    begin
                        ctx_next.wake_left = ctx_next.wake_left - elapsed_reg;
                    end
                end
                ctx_next.usb_time = sat_add16(ctx_next.usb_time, elapsed_reg);
                if (ctx_next.usb_time >= usb_period_reg)
                begin
                    ctx_next.usb_time = '0;
                    ctx_next = usb_event(ctx_next, level_reg, 1'b1, gate_reg, settle_reg);
                end
                if (ctx_next.mode == MODE_IDLE)
                begin
                    ctx_next.idle_time = sat_add16(ctx_next.idle_time, elapsed_reg);
                    if (ctx_next.idle_time >= settle_reg)
                    begin
                        ctx_next = evaluate(ctx_next, gate_reg, settle_reg);
                    end
                end
            end
            FUNC_LIGHT:
            begin
                ctx_next = level_event(cur, HB_LIGHT, level_reg, gate_reg, settle_reg);
            end
            FUNC_INDICATOR:
            begin
                ctx_next = level_event(cur, HB_INDICATOR, level_reg, gate_reg, settle_reg);
            end
            FUNC_USB:
            begin
                ctx_next = usb_event(cur, level_reg, allow_io_reg, gate_reg, settle_reg);
            end
            FUNC_USER_WAKE:
            begin
                ctx_next.holds[HB_BUTTON] = 1'b1;
                ctx_next.holds[HB_USER]   = 1'b1;
                ctx_next.wake_left        = user_hold_reg;
                ctx_next = go_active(ctx_next);
                ctx_next = evaluate(ctx_next, gate_reg, settle_reg);
            end
            FUNC_REMOTE:
            begin
                ctx_next.holds[HB_USER] = 1'b1;
                if (ctx_next.wake_left < matter_hold_reg)
                begin
                    ctx_next.wake_left = matter_hold_reg;
                end
                ctx_next = go_active(ctx_next);
                ctx_next = evaluate(ctx_next, gate_reg, settle_reg);
            end
            FUNC_COMMISSION:
            begin
                ctx_next = level_event(cur, HB_COMMISSION, level_reg, gate_reg, settle_reg);
            end
            default:
            begin
                ctx_next = cur;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg     <= func;
            level_reg    <= level;
            allow_io_reg <= allow_io;
            elapsed_reg  <= elapsed_ms;
        end
        if (work)
        begin
            run_state_reg     <= ctx_next.mode;
            hold_mask_reg     <= ctx_next.holds;
            suspended_out_reg <= ctx_next.suspended;
            suspend_pulse_reg <= ctx_next.pulse_suspend;
            resume_pulse_reg  <= ctx_next.pulse_resume;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg        <= GATE_RESET;
            settle_reg      <= IDLE_SETTLE_RESET;
            user_hold_reg   <= USER_HOLD_RESET;
            matter_hold_reg <= MATTER_HOLD_RESET;
            usb_period_reg  <= USB_PERIOD_RESET;
            mode_reg        <= MODE_ACTIVE;
            holds_reg       <= '0;
            idle_time_reg   <= '0;
            wake_left_reg   <= '0;
            usb_time_reg    <= '0;
            suspended_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_GATE_ON_IDLE:
                begin
                    gate_reg            <= cfg_data[0];
                    holds_reg[HB_DEBUG] <= !cfg_data[0];
                end
                CFG_IDLE_SETTLE: settle_reg      <= cfg_data;
                CFG_USER_HOLD:   user_hold_reg   <= cfg_data;
                CFG_MATTER_HOLD: matter_hold_reg <= cfg_data;
                CFG_USB_PERIOD:  usb_period_reg  <= cfg_data;
                default:         gate_reg        <= gate_reg;
            endcase
        end
        else if (work)
        begin
            mode_reg      <= ctx_next.mode;
            holds_reg     <= ctx_next.holds;
            idle_time_reg <= ctx_next.idle_time;
            wake_left_reg <= ctx_next.wake_left;
            usb_time_reg  <= ctx_next.usb_time;
            suspended_reg <= ctx_next.suspended;
        end
    end

    assign out_valid             = out_valid_reg;
    assign run_state             = run_state_reg;
    assign hold_mask             = hold_mask_reg;
    assign peripherals_suspended = suspended_out_reg;
    assign suspend_pulse         = suspend_pulse_reg;
    assign resume_pulse          = resume_pulse_reg;

    // A suspend beat always reports the sleep state with the peripherals down.
    `ISC_ASSERT_IMP(a_suspend_beat, clk, rst_n, out_valid_reg && suspend_pulse_reg, suspended_out_reg && (run_state_reg == MODE_SLEEP))
    // A resume beat never reports suspended peripherals or a suspend in the same beat.
    `ISC_ASSERT_IMP(a_resume_beat, clk, rst_n, out_valid_reg && resume_pulse_reg, !suspended_out_reg && !suspend_pulse_reg)
    // The debug force hold always mirrors the inverse of the gating register.
    `ISC_ASSERT_IMP(a_debug_hold, clk, rst_n, 1'b1, holds_reg[HB_DEBUG] == !gate_reg)
    // An item processed by the update stage appears as a result beat in the next cycle.
    `ISC_ASSERT_NEXT(a_work_result, clk, rst_n, work, out_valid_reg)

endmodule

FILE: test/idle_sleep_coordinator_unit_test.sv
// Self-checking testbench for the idle sleep coordinator: directed table, random phases, stalls.
`timescale 1ns / 100ps

module idle_sleep_coordinator_unit_test;
    import isc_pkg::*;

    localparam logic [2:0] FUNC_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD = 300;
    localparam int TAIL_CYCLES = 4;
    localparam int PHASE_ITEMS = 170;
    localparam int N_DIRECTED = 24;

    typedef struct packed {
        mode_t      run;
        logic [6:0] mask;
        logic       suspended;
        logic       suspend_pulse;
        logic       resume_pulse;
    } coord_view_t;

    typedef struct packed {
        logic [2:0]  fn;
        logic        lvl;
        logic        aio;
        logic [15:0] elapsed;
        logic        typed;
        coord_view_t want;
    } stim_row_t;

    typedef struct packed {
        coord_view_t model;
        logic        typed;
        coord_view_t typed_view;
    } awaited_t;

    localparam coord_view_t NO_VIEW = '0;

    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{FUNC_POLL,       1'b0, 1'b0, 16'h0000, 1'b1, '{MODE_ACTIVE, 7'h00, 1'b0, 1'b0, 1'b0}},
        '{FUNC_LIGHT,      1'b1, 1'b0, 16'h0000, 1'b1, '{MODE_ACTIVE, 7'h01, 1'b0, 1'b0, 1'b0}},
        '{FUNC_LIGHT,      1'b0, 1'b0, 16'h0000, 1'b1, '{MODE_IDLE,   7'h00, 1'b0, 1'b0, 1'b0}},
        '{FUNC_POLL,       1'b0, 1'b0, 16'hFFFF, 1'b1, '{MODE_SLEEP,  7'h00, 1'b1, 1'b1, 1'b0}},
        '{FUNC_INDICATOR,  1'b1, 1'b0, 16'h0000, 1'b1, '{MODE_ACTIVE, 7'h02, 1'b0, 1'b0, 1'b1}},
        '{FUNC_INDICATOR,  1'b0, 1'b0, 16'h0000, 1'b1, '{MODE_IDLE,   7'h00, 1'b0, 1'b0, 1'b0}},
        '{FUNC_USB,        1'b1, 1'b0, 16'h0000, 1'b1, '{MODE_ACTIVE, 7'h04, 1'b0, 1'b0, 1'b0}},
        '{FUNC_USB,        1'b0, 1'b0, 16'h0000, 1'b1, '{MODE_IDLE,   7'h00, 1'b0, 1'b0, 1'b0}},
        '{FUNC_USB,        1'b1, 1'b1, 16'h0000, 1'b1, '{MODE_ACTIVE, 7'h04, 1'b0, 1'b0, 1'b0}},
        '{FUNC_USB,        1'b0, 1'b1, 16'h0000, 1'b1, '{MODE_IDLE,   7'h00, 1'b0, 1'b0, 1'b0}},
        '{FUNC_USER_WAKE,  1'b0, 1'b0, 16'h0000, 1'b1, '{MODE_ACTIVE, 7'h18, 1'b0, 1'b0, 1'b0}},
        '{FUNC_POLL,       1'b0, 1'b0, 16'd1999, 1'b0, NO_VIEW},
        '{FUNC_POLL,       1'b0, 1'b0, 16'd1,    1'b0, NO_VIEW},
        '{FUNC_REMOTE,     1'b0, 1'b0, 16'h0000, 1'b0, NO_VIEW},
        '{FUNC_COMMISSION, 1'b1, 1'b1, 16'h0000, 1'b0, NO_VIEW},
        '{FUNC_COMMISSION, 1'b0, 1'b0, 16'h0000, 1'b0, NO_VIEW},
        '{FUNC_UNUSED,     1'b1, 1'b1, 16'hFFFF, 1'b0, NO_VIEW},
        '{FUNC_POLL,       1'b1, 1'b0, 16'hFFFF, 1'b0, NO_VIEW},
        '{FUNC_USB,        1'b0, 1'b1, 16'h0000, 1'b0, NO_VIEW},
        '{FUNC_POLL,       1'b0, 1'b0, 16'hFFFF, 1'b0, NO_VIEW},
        '{FUNC_USB,        1'b1, 1'b0, 16'h0000, 1'b0, NO_VIEW},
        '{FUNC_USB,        1'b0, 1'b0, 16'h0000, 1'b0, NO_VIEW},
        '{FUNC_POLL,       1'b0, 1'b0, 16'hFFFF, 1'b0, NO_VIEW},
        '{FUNC_REMOTE,     1'b1, 1'b1, 16'h0000, 1'b0, NO_VIEW}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  func;
    logic        level;
    logic        allow_io;
    logic [15:0] elapsed_ms;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  run_state;
    logic [6:0]  hold_mask;
    logic        peripherals_suspended;
    logic        suspend_pulse;
    logic        resume_pulse;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    logic        row_typed;
    coord_view_t row_want;

    // Predictor state and register copies.
    mode_t       pr_mode;
    logic [6:0]  pr_holds;
    logic [15:0] pr_idle;
    logic [15:0] pr_wake_left;
    logic [15:0] pr_usb_time;
    logic        pr_suspended;
    logic        pr_pulse_sus;
    logic        pr_pulse_res;
    logic        r_gate;
    logic [15:0] r_settle;
    logic [15:0] r_user_hold;
    logic [15:0] r_remote_hold;
    logic [15:0] r_usb_period;

    awaited_t    awaited_results [$];
    int          failures;
    int          burst_left;
    int          cycle_count;
    bit          stall_request;
    bit          stall_done;

    idle_sleep_coordinator_unit uut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_valid              (in_valid),
        .in_ready              (in_ready),
        .func                  (func),
        .level                 (level),
        .allow_io              (allow_io),
        .elapsed_ms            (elapsed_ms),
        .out_valid             (out_valid),
        .out_ready             (out_ready),
        .run_state             (run_state),
        .hold_mask             (hold_mask),
        .peripherals_suspended (peripherals_suspended),
        .suspend_pulse         (suspend_pulse),
        .resume_pulse          (resume_pulse),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data)
    );

    function automatic logic [15:0] add_clamped(logic [15:0] a, logic [15:0] b);
        if (32'(a) + 32'(b) > 32'hFFFF)
        begin
            return 16'hFFFF;
        end
        return a + b;
    endfunction

    function automatic void wake_peripherals();
        if (pr_suspended)
        begin
            pr_suspended = 1'b0;
            pr_pulse_res = 1'b1;
        end
    endfunction

    function automatic void make_active();
        wake_peripherals();
        pr_idle = '0;
        pr_mode = MODE_ACTIVE;
    endfunction

    function automatic void reassess();
        if (!r_gate || (pr_holds != '0))
        begin
            make_active();
        end
        else if (pr_mode != MODE_SLEEP)
        begin
            if (pr_mode != MODE_IDLE)
            begin
                pr_idle = '0;
                pr_mode = MODE_IDLE;
            end
            else if (pr_idle >= r_settle)
            begin
                pr_suspended = 1'b1;
                pr_pulse_sus = 1'b1;
                pr_mode = MODE_SLEEP;
            end
        end
    endfunction

    function automatic void usb_change(logic present, logic io_ok);
        pr_holds[HB_USB] = present;
        if (!io_ok)
        begin
            if (present)
            begin
                pr_idle = '0;
                pr_mode = MODE_ACTIVE;
            end
            else if ((pr_holds == '0) && (pr_mode == MODE_ACTIVE))
            begin
                pr_idle = '0;
                pr_mode = MODE_IDLE;
            end
        end
        else
        begin
            if (present)
            begin
                make_active();
            end
            reassess();
        end
    endfunction

    function automatic void hold_change(int bit_pos, logic lvl);
        pr_holds[bit_pos] = lvl;
        if (lvl)
        begin
            make_active();
        end
        reassess();
    endfunction

    function automatic void poll_tick(logic usb_lvl, logic [15:0] elapsed);
        if (pr_wake_left != '0)
        begin
            if (elapsed >= pr_wake_left)
            begin
                pr_wake_left = '0;
                pr_holds[HB_BUTTON] = 1'b0;
                pr_holds[HB_USER] = 1'b0;
                reassess();
            end
            else
            begin
                pr_wake_left = pr_wake_left - elapsed;
            end
        end
        pr_usb_time = add_clamped(pr_usb_time, elapsed);
        if (pr_usb_time >= r_usb_period)
        begin
            pr_usb_time = '0;
            usb_change(usb_lvl, 1'b1);
        end
        if (pr_mode == MODE_IDLE)
        begin
            pr_idle = add_clamped(pr_idle, elapsed);
            if (pr_idle >= r_settle)
            begin
                reassess();
            end
        end
    endfunction

    function automatic coord_view_t predict_coordinator(logic [2:0] fn, logic lvl, logic aio,
                                                        logic [15:0] elapsed);
        pr_pulse_sus = 1'b0;
        pr_pulse_res = 1'b0;
        case (fn)
            FUNC_POLL:       poll_tick(lvl, elapsed);
            FUNC_LIGHT:      hold_change(HB_LIGHT, lvl);
            FUNC_INDICATOR:  hold_change(HB_INDICATOR, lvl);
            FUNC_USB:        usb_change(lvl, aio);
            FUNC_USER_WAKE:
            begin
                pr_holds[HB_BUTTON] = 1'b1;
                pr_holds[HB_USER] = 1'b1;
                pr_wake_left = r_user_hold;
                make_active();
                reassess();
            end
            FUNC_REMOTE:
            begin
                wake_peripherals();
                pr_holds[HB_USER] = 1'b1;
                if (pr_wake_left < r_remote_hold)
                begin
                    pr_wake_left = r_remote_hold;
                end
                make_active();
                reassess();
            end
            FUNC_COMMISSION: hold_change(HB_COMMISSION, lvl);
            default:
            begin
            end
        endcase
        return '{pr_mode, pr_holds, pr_suspended, pr_pulse_sus, pr_pulse_res};
    endfunction

    function automatic void apply_register(logic [2:0] idx, logic [15:0] value);
        case (idx)
            CFG_GATE_ON_IDLE:
            begin
                r_gate = value[0];
                pr_holds[HB_DEBUG] = ~value[0];
            end
            CFG_IDLE_SETTLE: r_settle = value;
            CFG_USER_HOLD:   r_user_hold = value;
            CFG_MATTER_HOLD: r_remote_hold = value;
            CFG_USB_PERIOD:  r_usb_period = value;
            default:
            begin
            end
        endcase
    endfunction

    function automatic void compare_view(string source, coord_view_t want, coord_view_t got);
        if (want.run !== got.run)
        begin
            $error("%s run_state: expected %0d, actual %0d", source, want.run, got.run);
            failures++;
        end
        if (want.mask !== got.mask)
        begin
            $error("%s hold_mask: expected 0x%02h, actual 0x%02h", source, want.mask, got.mask);
            failures++;
        end
        if (want.suspended !== got.suspended)
        begin
            $error("%s peripherals_suspended: expected %0d, actual %0d", source,
                   want.suspended, got.suspended);
            failures++;
        end
        if (want.suspend_pulse !== got.suspend_pulse)
        begin
            $error("%s suspend_pulse: expected %0d, actual %0d", source,
                   want.suspend_pulse, got.suspend_pulse);
            failures++;
        end
        if (want.resume_pulse !== got.resume_pulse)
        begin
            $error("%s resume_pulse: expected %0d, actual %0d", source,
                   want.resume_pulse, got.resume_pulse);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        awaited_t    head;
        coord_view_t seen;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                apply_register(cfg_index, cfg_data);
            end
            if (in_valid && in_ready)
            begin
                head.model = predict_coordinator(func, level, allow_io, elapsed_ms);
                head.typed = row_typed;
                head.typed_view = row_want;
                awaited_results.push_back(head);
            end
            if (out_valid && out_ready)
            begin
                seen = '{mode_t'(run_state), hold_mask, peripherals_suspended,
                         suspend_pulse, resume_pulse};
                if (awaited_results.size() == 0)
                begin
                    $error("result beat with no item outstanding");
                    failures++;
                end
                else
                begin
                    head = awaited_results.pop_front();
                    compare_view("predicted", head.model, seen);
                    if (head.typed)
                    begin
                        compare_view("directed", head.typed_view, seen);
                    end
                end
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // The receiver mixes open stretches, random stalls and short closures; once asked, it
    // refuses every result beat for a long stretch so that the block backs up.
    initial
    begin
        int kind;
        int span;
        out_ready <= 1'b0;
        forever
        begin
            if (stall_request && !stall_done)
            begin
                stall_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            kind = $urandom_range(0, 9);
            span = $urandom_range(1, 30);
            repeat (span)
            begin
                if (kind < 4)
                begin
                    out_ready <= 1'b1;
                end
                else if (kind < 8)
                begin
                    out_ready <= ($urandom_range(0, 2) != 0);
                end
                else
                begin
                    out_ready <= 1'b0;
                end
                @(posedge clk);
            end
        end
    end

    task automatic send_item(logic [2:0] fn, logic lvl, logic aio, logic [15:0] elapsed,
                             logic typed, coord_view_t want);
        in_valid <= 1'b1;
        func <= fn;
        level <= lvl;
        allow_io <= aio;
        elapsed_ms <= elapsed;
        row_typed <= typed;
        row_want <= want;
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(cfg_index_t idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Quiet runs of polls with no USB let the block settle and reach the suspend.
    task automatic random_items(int count);
        int          made;
        int          quiet;
        int          pick;
        logic [2:0]  fn;
        logic        lvl;
        logic [15:0] elapsed;
        made = 0;
        quiet = 0;
        while (made < count)
        begin
            if ((quiet == 0) && ($urandom_range(0, 7) == 0))
            begin
                quiet = $urandom_range(3, 12);
            end
            if (quiet > 0)
            begin
                fn = FUNC_POLL;
                lvl = 1'b0;
                quiet--;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    fn = FUNC_POLL;
                else if (pick < 55)
                    fn = FUNC_LIGHT;
                else if (pick < 63)
                    fn = FUNC_INDICATOR;
                else if (pick < 73)
                    fn = FUNC_USB;
                else if (pick < 81)
                    fn = FUNC_USER_WAKE;
                else if (pick < 86)
                    fn = FUNC_REMOTE;
                else if (pick < 95)
                    fn = FUNC_COMMISSION;
                else
                    fn = FUNC_UNUSED;
                if (fn == FUNC_POLL)
                    lvl = ($urandom_range(0, 3) == 0);
                else
                    lvl = ($urandom_range(0, 2) == 0);
            end
            case ($urandom_range(0, 9))
                0:       elapsed = 16'h0000;
                1:       elapsed = 16'hFFFF;
                2:       elapsed = 16'($urandom_range(0, 65535));
                default: elapsed = 16'($urandom_range(0, 400));
            endcase
            send_item(fn, lvl, 1'($urandom_range(0, 1)), elapsed, 1'b0, NO_VIEW);
            if (fn != FUNC_UNUSED)
            begin
                made++;
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        func <= FUNC_POLL;
        level <= 1'b0;
        allow_io <= 1'b0;
        elapsed_ms <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_GATE_ON_IDLE;
        cfg_data <= '0;
        row_typed <= 1'b0;
        row_want <= NO_VIEW;
        failures = 0;
        burst_left = $urandom_range(1, 12);
        stall_request = 1'b0;
        stall_done = 1'b0;
        r_gate = GATE_RESET;
        r_settle = IDLE_SETTLE_RESET;
        r_user_hold = USER_HOLD_RESET;
        r_remote_hold = MATTER_HOLD_RESET;
        r_usb_period = USB_PERIOD_RESET;
        pr_mode = MODE_ACTIVE;
        pr_holds = '0;
        pr_idle = '0;
        pr_wake_left = '0;
        pr_usb_time = '0;
        pr_suspended = 1'b0;
        pr_pulse_sus = 1'b0;
        pr_pulse_res = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_item(DIRECTED_ROWS[i].fn, DIRECTED_ROWS[i].lvl, DIRECTED_ROWS[i].aio,
                      DIRECTED_ROWS[i].elapsed, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end
        random_items(PHASE_ITEMS);

        for (int phase = 1; phase <= 5; phase++)
        begin
            wait_results();
            case (phase)
                1:
                begin
                    write_register(CFG_GATE_ON_IDLE, 16'd0);
                    write_register(CFG_IDLE_SETTLE, 16'd0);
                    write_register(CFG_USER_HOLD, 16'd0);
                    write_register(CFG_MATTER_HOLD, 16'd0);
                    write_register(CFG_USB_PERIOD, 16'd1);
                end
                2:
                begin
                    write_register(CFG_GATE_ON_IDLE, 16'd1);
                    write_register(CFG_IDLE_SETTLE, 16'hFFFF);
                    write_register(CFG_USER_HOLD, 16'hFFFF);
                    write_register(CFG_MATTER_HOLD, 16'hFFFF);
                    write_register(CFG_USB_PERIOD, 16'hFFFF);
                end
                3:
                begin
                    write_register(CFG_IDLE_SETTLE, 16'd100);
                    write_register(CFG_USER_HOLD, 16'd300);
                    write_register(CFG_MATTER_HOLD, 16'd600);
                    write_register(CFG_USB_PERIOD, 16'd0);
                end
                4:
                begin
                    write_register(CFG_IDLE_SETTLE, 16'($urandom_range(0, 2000)));
                    write_register(CFG_USER_HOLD, 16'($urandom_range(0, 3000)));
                    write_register(CFG_MATTER_HOLD, 16'($urandom_range(0, 5000)));
                    write_register(CFG_USB_PERIOD, 16'($urandom_range(1, 3000)));
                end
                default:
                begin
                    write_register(CFG_GATE_ON_IDLE, 16'd1);
                    write_register(CFG_IDLE_SETTLE, 16'($urandom_range(0, 65535)));
                    write_register(CFG_USER_HOLD, 16'($urandom_range(0, 65535)));
                    write_register(CFG_MATTER_HOLD, 16'($urandom_range(0, 65535)));
                    write_register(CFG_USB_PERIOD, 16'($urandom_range(0, 65535)));
                end
            endcase
            if (phase == 1)
            begin
                stall_request = 1'b1;
            end
            random_items(PHASE_ITEMS);
        end

        wait_results();
        if (failures == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/isc_pkg.sv
src/idle_sleep_coordinator_unit.sv
test/idle_sleep_coordinator_unit_test.sv
